// ===== hw/rtl/brsi_pkg.sv =====
// Shared types and constants for the bounded recency sorted insert block.
package brsi_pkg;

  localparam logic [5:0] DEFAULT_LIMIT = 6'd25;
  localparam logic [5:0] LIMIT_RESET   = 6'd25;

  // Register word index (paddr[2]).
  localparam logic REG_LIST_LIMIT = 1'b0;

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } brsi_state_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic        probe;      // latch compare flags against tstamp
    logic        commit;     // apply the update
    logic        do_insert;  // sorted insertion with shift
    logic        do_append;  // write at the tail slot
    logic [31:0] tstamp;
    logic [31:0] id;
  } brsi_ctrl_t;

  // What a cell hands to its older neighbor.
  typedef struct packed {
    logic        valid;
    logic        gt;
    logic [31:0] tstamp;
    logic [31:0] id;
  } brsi_link_t;

  // Per-cell status collected by the top level.
  typedef struct packed {
    logic        hit;
    logic        last_lt;
    logic [31:0] last_id;
  } brsi_stat_t;

endpackage

// ===== hw/rtl/brsi_ifs.sv =====
// Valid/ready channel interfaces for event items and result items.
interface brsi_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] event_time;
  logic [31:0] item_id;

  modport source (output valid, output event_time, output item_id, input ready);
  modport sink (input valid, input event_time, input item_id, output ready);
endinterface

interface brsi_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [4:0]  insert_position;
  logic        evicted;
  logic [31:0] evicted_id;
  logic [5:0]  entry_count;

  modport source (output valid, output accepted, output insert_position,
                  output evicted, output evicted_id, output entry_count,
                  input ready);
  modport sink (input valid, input accepted, input insert_position,
                input evicted, input evicted_id, input entry_count,
                output ready);
endinterface

// ===== hw/rtl/brsi_cell.sv =====
// One list slot: holds an entry, compares it and shifts from its newer neighbor.
module brsi_cell #(
  parameter int MAX_ENTRIES = 32,
  parameter int IDX         = 0
) (
  input  logic                                clk,
  input  brsi_pkg::brsi_ctrl_t                ctrl,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]    count,
  input  brsi_pkg::brsi_link_t                prev,
  output brsi_pkg::brsi_link_t                next,
  output brsi_pkg::brsi_stat_t                stat
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW:0]   IDX_P1 = (CW + 1)'(IDX + 1);

  logic [31:0] tstamp_r;
  logic [31:0] id_r;
  logic        gt_r;
  logic        lt_r;

  logic valid;
  logic is_last;
  logic is_tail;
  logic gt_m;
  logic hit;
  logic takes;

  assign valid   = IDX_C < count;
  assign is_last = IDX_P1 == {1'b0, count};
  assign is_tail = IDX_C == count;
  assign gt_m    = valid & gt_r;
  // first slot not newer than the event; the gt flags form a prefix
  assign hit     = valid & ~gt_m & prev.gt;
  assign takes   = prev.valid & ~prev.gt;

  assign next.valid  = valid;
  assign next.gt     = gt_m;
  assign next.tstamp = tstamp_r;
  assign next.id     = id_r;

  assign stat.hit     = hit;
  assign stat.last_lt = is_last & lt_r;
  assign stat.last_id = is_last ? id_r : 32'd0;

  always_ff @(posedge clk) begin
    if (ctrl.probe) begin
      gt_r <= tstamp_r > ctrl.tstamp;
      lt_r <= tstamp_r < ctrl.tstamp;
    end
    if (ctrl.commit) begin
      if (ctrl.do_insert) begin
        if (hit) begin
          tstamp_r <= ctrl.tstamp;
          id_r     <= ctrl.id;
        end else if (takes) begin
          tstamp_r <= prev.tstamp;
          id_r     <= prev.id;
        end
      end else if (ctrl.do_append && is_tail) begin
        tstamp_r <= ctrl.tstamp;
        id_r     <= ctrl.id;
      end
    end
  end

endmodule

// ===== hw/rtl/bounded_recency_sorted_insert.sv =====
// Top level: sorted newest-first recency list built as a chain of slot cells.
//
// The block keeps up to list_limit (timestamp, id) entries sorted newest
// first, one entry per cell of a chain of MAX_ENTRIES cells. At the edge
// an event item is accepted, every cell latches how its stored timestamp
// compares with the event's; at the commit edge that follows, the cells
// write the event, shift their newer neighbor's entry in or hold, and the
// result item is registered. The next event can be accepted in the cycle
// after that commit, not while one awaits commit, and the work per item is
// independent of list length. The commit waits while a previous result is
// still not taken; an event may be accepted while a result waits.
// A list_limit of zero means 25 (capped at MAX_ENTRIES), and values above
// MAX_ENTRIES mean MAX_ENTRIES. Lowering the limit below the current count
// keeps the count: appends are dropped and each insertion evicts the last
// entry. The list_limit register sits at byte address 0 of the APB port.
module bounded_recency_sorted_insert #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  brsi_in_if.sink            in_chan,
  brsi_out_if.source         out_chan,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int CW      = $clog2(MAX_ENTRIES + 1);
  localparam int IW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int DEF_LIM = (int'(brsi_pkg::DEFAULT_LIMIT) > MAX_ENTRIES) ?
                           MAX_ENTRIES : int'(brsi_pkg::DEFAULT_LIMIT);

  // ---------------- configuration ----------------
  logic [5:0] limit_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= brsi_pkg::LIMIT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == brsi_pkg::REG_LIST_LIMIT) begin
      limit_r <= cfg_pwdata[5:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == brsi_pkg::REG_LIST_LIMIT) begin
      cfg_prdata = {26'd0, limit_r};
    end else begin
      cfg_prdata = 32'd0;
    end
  end

  // effective limit, always 1..MAX_ENTRIES
  logic [CW-1:0] lim;
  always_comb begin
    if (limit_r == 6'd0) begin
      lim = CW'(DEF_LIM);
    end else if (32'(limit_r) > 32'(MAX_ENTRIES)) begin
      lim = CW'(MAX_ENTRIES);
    end else begin
      lim = CW'(limit_r);
    end
  end

  // ---------------- sequencer ----------------
  brsi_pkg::brsi_state_t state_r, state_nxt;
  logic        in_acc;
  logic        commit_go;
  logic [31:0] item_time_r;
  logic [31:0] item_id_r;
  logic        out_valid_r, out_valid_nxt;

  assign in_acc = in_chan.valid & in_chan.ready;

  // outputs of the sequencer
  always_comb begin
    in_chan.ready = 1'b0;
    commit_go     = 1'b0;
    case (state_r)
      brsi_pkg::S_IDLE: begin
        in_chan.ready = 1'b1;
      end
      brsi_pkg::S_COMMIT: begin
        commit_go = ~out_valid_r | out_chan.ready;
      end
      default: begin
        in_chan.ready = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brsi_pkg::S_IDLE: begin
        if (in_acc) state_nxt = brsi_pkg::S_COMMIT;
      end
      brsi_pkg::S_COMMIT: begin
        if (commit_go) state_nxt = brsi_pkg::S_IDLE;
      end
      default: begin
        state_nxt = brsi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brsi_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_time_r <= in_chan.event_time;
      item_id_r   <= in_chan.item_id;
    end
  end

  // ---------------- cell chain ----------------
  logic [CW-1:0]        count_r, count_nxt;
  brsi_pkg::brsi_ctrl_t ctrl;
  brsi_pkg::brsi_link_t link [MAX_ENTRIES+1];
  brsi_pkg::brsi_stat_t stat [MAX_ENTRIES];

  // head of the chain: behaves as an infinitely new, invalid neighbor
  assign link[0] = '{valid: 1'b0, gt: 1'b1, tstamp: 32'd0, id: 32'd0};

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    brsi_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX         (g)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .count (count_r),
      .prev  (link[g]),
      .next  (link[g+1]),
      .stat  (stat[g])
    );
  end

  // collect cell status
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [IW-1:0]          hit_idx;
  logic                   last_lt;
  logic [31:0]            last_id;

  always_comb begin
    hit_idx = '0;
    last_lt = 1'b0;
    last_id = 32'd0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = stat[i].hit;
      if (stat[i].hit) hit_idx = hit_idx | IW'(i);
      last_lt = last_lt | stat[i].last_lt;
      last_id = last_id | stat[i].last_id;
    end
  end

  // decision for the pending item
  logic        empty;
  logic        append;
  logic        drop;
  logic        insert;
  logic        evict;
  logic [31:0] pos_word;
  logic [31:0] cnt_word;

  assign empty  = count_r == '0;
  // append when the oldest entry is not older than the event
  assign append = empty | ~last_lt;
  assign drop   = append & (count_r >= lim);
  assign insert = ~append;
  assign evict  = insert & (count_r >= lim);

  always_comb begin
    if ((append && !drop) || (insert && !evict)) begin
      count_nxt = count_r + CW'(1);
    end else begin
      count_nxt = count_r;
    end
    if (drop) begin
      pos_word = 32'd0;
    end else if (append) begin
      pos_word = 32'(count_r);
    end else begin
      pos_word = 32'(hit_idx);
    end
  end

  assign cnt_word = 32'(count_nxt);

  assign ctrl.probe     = in_acc;
  assign ctrl.commit    = commit_go;
  assign ctrl.do_insert = insert;
  assign ctrl.do_append = append & ~drop;
  assign ctrl.tstamp    = in_acc ? in_chan.event_time : item_time_r;
  assign ctrl.id        = item_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (commit_go) begin
      count_r <= count_nxt;
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_chan.accepted        <= ~drop;
      out_chan.insert_position <= pos_word[4:0];
      out_chan.evicted         <= evict;
      out_chan.evicted_id      <= evict ? last_id : 32'd0;
      out_chan.entry_count     <= cnt_word[5:0];
    end
  end

  assign out_chan.valid = out_valid_r;

  // ---------------- assertions ----------------
  // an insertion always finds exactly one slot
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == brsi_pkg::S_COMMIT && insert) |-> $onehot(hit_vec))
    else $error("insertion without a unique target slot");

  // the count moves only when an item commits
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit_go |=> count_r == $past(count_r))
    else $error("entry count changed without a commit");

  // starting below the limit, a commit never grows the list past it
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_go && count_r < lim) |=> count_r <= $past(lim))
    else $error("entry count exceeded the limit");

  // the tail cell is valid exactly when the list is at capacity
  a_tail_valid: assert property (@(posedge clk) disable iff (!rst_n)
    link[MAX_ENTRIES].valid == (count_r == CW'(MAX_ENTRIES)))
    else $error("cell validity disagrees with the entry count");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for bounded_recency_sorted_insert: directed table, random events, scoreboard.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_SLOTS    = 32;
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off, fills the block
  localparam int IDLE_LIMIT   = 3000;  // cycles with no handshake before giving up
  localparam int PHASE_EVENTS = 50;
  localparam int NUM_PHASES   = 8;

  // One result item as the block reports it.
  typedef struct packed {
    logic        accepted;
    logic [4:0]  insert_position;
    logic        evicted;
    logic [31:0] evicted_id;
    logic [5:0]  entry_count;
  } recency_result_t;

  typedef enum logic {
    ROW_EVENT,
    ROW_LIMIT
  } row_kind_t;

  // Directed row: an event, or a new list_limit (held in ts) written while idle.
  // The expected result is typed in only where it is obvious; else predicted.
  typedef struct packed {
    row_kind_t       kind;
    logic [31:0]     ts;
    logic [31:0]     id;
    logic            known;
    recency_result_t want;
  } stim_row_t;

  localparam recency_result_t NO_WANT = '0;
  localparam int NUM_ROWS = 18;

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // empty list takes position 0
    '{ROW_EVENT, 32'd100, 32'h0000_0011, 1'b1, '{1'b1, 5'd0, 1'b0, 32'd0, 6'd1}},
    // newer event goes in front
    '{ROW_EVENT, 32'd200, 32'h0000_0022, 1'b1, '{1'b1, 5'd0, 1'b0, 32'd0, 6'd2}},
    // equal to the oldest timestamp: appended at the tail
    '{ROW_EVENT, 32'd100, 32'h0000_0033, 1'b1, '{1'b1, 5'd2, 1'b0, 32'd0, 6'd3}},
    // oldest possible timestamp, id zero
    '{ROW_EVENT, 32'd0, 32'h0000_0000, 1'b1, '{1'b1, 5'd3, 1'b0, 32'd0, 6'd4}},
    // newest possible timestamp, all-ones id
    '{ROW_EVENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 5'd0, 1'b0, 32'd0, 6'd5}},
    // mid-list insertion
    '{ROW_EVENT, 32'd150, 32'h0000_0044, 1'b0, NO_WANT},
    // tie in the middle: lands before the equal entries
    '{ROW_EVENT, 32'd100, 32'h0000_0055, 1'b0, NO_WANT},
    // limit dropped well below the current count
    '{ROW_LIMIT, 32'd1, 32'd0, 1'b0, NO_WANT},
    // append case with the list over its limit: dropped, count unchanged
    '{ROW_EVENT, 32'd0, 32'h0000_0066, 1'b1, '{1'b0, 5'd0, 1'b0, 32'd0, 6'd7}},
    // insertion over the limit evicts only the tail, count unchanged
    '{ROW_EVENT, 32'd50, 32'h0000_0077, 1'b0, NO_WANT},
    '{ROW_EVENT, 32'hFFFF_FFFF, 32'h0000_0088, 1'b0, NO_WANT},
    // zero means the default limit
    '{ROW_LIMIT, 32'd0, 32'd0, 1'b0, NO_WANT},
    '{ROW_EVENT, 32'd1, 32'h0000_0099, 1'b0, NO_WANT},
    // beyond capacity clamps to MAX_ENTRIES
    '{ROW_LIMIT, 32'd63, 32'd0, 1'b0, NO_WANT},
    '{ROW_EVENT, 32'd300, 32'h0000_00AA, 1'b0, NO_WANT},
    '{ROW_LIMIT, 32'd32, 32'd0, 1'b0, NO_WANT},
    '{ROW_EVENT, 32'd7, 32'h0000_00BB, 1'b0, NO_WANT},
    '{ROW_LIMIT, 32'd25, 32'd0, 1'b0, NO_WANT}
  };

  // Limits per random phase; lowering steps (63->3, 32->1, 45->12, 12->2) hit the
  // over-limit behavior, 63, 32 and 45 reach the full-storage eviction.
  localparam logic [5:0] PHASE_LIMITS [NUM_PHASES] = '{
    6'd0, 6'd63, 6'd3, 6'd32, 6'd1, 6'd45, 6'd12, 6'd2
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  brsi_in_if  in_ch();
  brsi_out_if out_ch();

  bounded_recency_sorted_insert #(.MAX_ENTRIES(MAX_SLOTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_ch),
    .out_chan    (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the list, kept newest first, plus the shadow limit register.
  logic [31:0] list_ts [MAX_SLOTS];
  logic [31:0] list_id [MAX_SLOTS];
  int          list_fill;
  logic [5:0]  shadow_limit;

  recency_result_t expected_results [$];
  recency_result_t head_want;

  int   mismatches;
  int   idle_cycles;
  int   n_events;
  int   n_dropped;
  int   n_evicted;
  int   n_checked;
  int   n_settings;
  logic no_idle;
  logic hold_req;
  logic [31:0] clock_now;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Predict one event against the shadow list and update it.
  function automatic recency_result_t predict_event(input logic [31:0] ts,
                                                    input logic [31:0] id);
    recency_result_t r;
    int lim;
    int n;
    int pos;
    int i;
    lim = (shadow_limit == 6'd0) ? int'(brsi_pkg::DEFAULT_LIMIT) : int'(shadow_limit);
    if (lim > MAX_SLOTS) lim = MAX_SLOTS;
    n = list_fill;
    r = '0;
    r.accepted = 1'b1;
    if (n == 0) begin
      list_ts[0] = ts;
      list_id[0] = id;
      n = 1;
    end else if (list_ts[n-1] >= ts) begin
      // not newer than the tail: append if room, else drop
      if (n >= lim) begin
        r.accepted = 1'b0;
      end else begin
        list_ts[n] = ts;
        list_id[n] = id;
        r.insert_position = 5'(n);
        n++;
      end
    end else begin
      // before the first entry not strictly newer
      pos = 0;
      while (pos < n - 1 && list_ts[pos] > ts) pos++;
      if (n >= MAX_SLOTS) begin
        // storage full: tail leaves before the shift
        r.evicted    = 1'b1;
        r.evicted_id = list_id[n-1];
        n--;
      end
      for (i = n; i > pos; i--) begin
        list_ts[i] = list_ts[i-1];
        list_id[i] = list_id[i-1];
      end
      list_ts[pos] = ts;
      list_id[pos] = id;
      n++;
      if (!r.evicted && n > lim) begin
        r.evicted    = 1'b1;
        r.evicted_id = list_id[n-1];
        n--;
      end
      r.insert_position = 5'(pos);
    end
    list_fill     = n;
    r.entry_count = 6'(n);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic cfg_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {brsi_pkg::REG_LIST_LIMIT, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Wait until every result is back and the pipeline has settled.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_list_limit(input logic [5:0] value);
    logic [31:0] rd;
    drain();
    cfg_access(1'b1, {26'd0, value}, rd);
    shadow_limit = value;
    n_settings++;
    cfg_access(1'b0, 32'd0, rd);
    if (rd !== {26'd0, value}) report_mismatch("list_limit readback", {26'd0, value}, rd);
  endtask

  // Offer one event item; predicted (or tabled) result is queued at acceptance.
  task automatic offer_event(input logic [31:0] ts, input logic [31:0] id,
                             input logic use_table, input recency_result_t table_want);
    int gap;
    recency_result_t pred;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.event_time = ts;
    in_ch.item_id    = id;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pred = predict_event(ts, id);
    expected_results.push_back(use_table ? table_want : pred);
    n_events++;
    if (!pred.accepted) n_dropped++;
    if (pred.evicted) n_evicted++;
  endtask

  // Random timestamps mostly track a moving "now" so the list fills and
  // stays sorted-interesting; the rest are ties, stale and wild values.
  function automatic logic [31:0] pick_timestamp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      clock_now = clock_now + $urandom_range(0, 20);
      return clock_now;
    end
    if (r < 70) return clock_now - $urandom_range(0, 200);
    if (r < 80 && list_fill > 0) return list_ts[$urandom_range(0, list_fill - 1)];
    if (r < 90) return clock_now - $urandom_range(1000, 100000);
    return $urandom;
  endfunction

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        if (!no_idle) stall = pick_gap();
      end
    end
  end

  // Scoreboard: each result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with none pending", 32'd0, 32'd1);
      end else begin
        head_want = expected_results.pop_front();
        n_checked++;
        if (out_ch.accepted !== head_want.accepted)
          report_mismatch("accepted", 32'(head_want.accepted), 32'(out_ch.accepted));
        if (out_ch.insert_position !== head_want.insert_position)
          report_mismatch("insert_position", 32'(head_want.insert_position),
                          32'(out_ch.insert_position));
        if (out_ch.evicted !== head_want.evicted)
          report_mismatch("evicted", 32'(head_want.evicted), 32'(out_ch.evicted));
        if (out_ch.evicted_id !== head_want.evicted_id)
          report_mismatch("evicted_id", head_want.evicted_id, out_ch.evicted_id);
        if (out_ch.entry_count !== head_want.entry_count)
          report_mismatch("entry_count", 32'(head_want.entry_count),
                          32'(out_ch.entry_count));
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired, %0d results still pending", expected_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] rd;
    int p;
    int k;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.event_time = '0;
    in_ch.item_id    = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    list_fill    = 0;
    shadow_limit = brsi_pkg::LIMIT_RESET;
    mismatches   = 0;
    idle_cycles  = 0;
    n_events     = 0;
    n_dropped    = 0;
    n_evicted    = 0;
    n_checked    = 0;
    n_settings   = 0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    clock_now    = $urandom;

    // synchronous reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // limit register comes out of reset at its default
    cfg_access(1'b0, 32'd0, rd);
    if (rd !== {26'd0, brsi_pkg::LIMIT_RESET})
      report_mismatch("list_limit after reset", {26'd0, brsi_pkg::LIMIT_RESET}, rd);

    // directed table
    for (k = 0; k < NUM_ROWS; k++) begin
      if (DIRECTED_ROWS[k].kind == ROW_LIMIT)
        set_list_limit(DIRECTED_ROWS[k].ts[5:0]);
      else
        offer_event(DIRECTED_ROWS[k].ts, DIRECTED_ROWS[k].id,
                    DIRECTED_ROWS[k].known, DIRECTED_ROWS[k].want);
    end

    // random phases, one list_limit each; some without any idling
    for (p = 0; p < NUM_PHASES; p++) begin
      set_list_limit(PHASE_LIMITS[p]);
      no_idle = (p % 3 == 1);
      // in the phase with limit 3 the receiver stalls long while events keep coming
      if (p == 2) hold_req = 1'b1;
      for (k = 0; k < PHASE_EVENTS; k++)
        offer_event(pick_timestamp(), $urandom, 1'b0, NO_WANT);
    end

    drain();
    no_idle = 1'b0;
    repeat (8) @(posedge clk);

    $display("Run: %0d events over %0d limit settings, %0d results checked.",
             n_events, n_settings, n_checked);
    $display("     %0d dropped, %0d evictions, %0d mismatches.",
             n_dropped, n_evicted, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
